// ===== rtl/fifo_with_slot_reservation_defines.svh =====
// assertion macros shared by the queue rtl
// no dependencies; taken in by the top level with an include
`ifndef FIFO_WITH_SLOT_RESERVATION_DEFINES_SVH
`define FIFO_WITH_SLOT_RESERVATION_DEFINES_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define FWSR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked at every edge, reset included
`define FWSR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define FWSR_ASSERT(label, prop, msg)
`define FWSR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/fwsr_pkg.sv =====
// types, codes and defaults for the queue with slot reservation
// no dependencies
`default_nettype none

package fwsr_pkg;

    localparam int FWSR_DEPTH      = 16;
    localparam int FWSR_DATA_WIDTH = 32;

    localparam int ACTION_W = 2;
    localparam int WORD_W   = 32;
    localparam int CAP_W    = 5;
    localparam int RCOUNT_W = 5;
    localparam int STATUS_W = 2;
    localparam int STORED_W = 5;
    localparam int RES_W    = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [RES_W-1:0] RES_MAX   = 8'd255;

    // actions
    localparam logic [ACTION_W-1:0] ACT_STATUS  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP     = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_RESERVE = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic                go;
        logic [ACTION_W-1:0] action;
    } step_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                head_valid;
        logic [STORED_W-1:0] stored_count;
        logic [RES_W-1:0]    reserved_slots;
        logic                is_full;
        logic                is_empty;
        logic                is_oversubscribed;
    } stat_t;

    // m_tdata layout, lowest bits last
    typedef struct packed {
        logic [6:0]          pad;
        logic                is_oversubscribed;
        logic                is_empty;
        logic                is_full;
        logic [RES_W-1:0]    reserved_slots;
        logic [STORED_W-1:0] stored_count;
        logic                head_valid;
        logic [WORD_W-1:0]   head_data;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/fwsr_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module fwsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/fwsr_ctrl.sv =====
// pointers, word and reservation counts, status and flags of the queue
// depends on fwsr_pkg
`default_nettype none

module fwsr_ctrl #(
    parameter int DEPTH = fwsr_pkg::FWSR_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire fwsr_pkg::step_t                   step,
    input  wire logic [fwsr_pkg::RCOUNT_W-1:0]     reserve_count,
    input  wire logic [fwsr_pkg::CAP_W-1:0]        capacity,
    output logic                                   wr_en,
    output logic      [$clog2(DEPTH)-1:0]          wr_addr,
    output logic      [$clog2(DEPTH)-1:0]          rd_addr,
    output fwsr_pkg::stat_t                        stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int UW = ((CW > fwsr_pkg::RES_W) ? CW : fwsr_pkg::RES_W) + 1;
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

    logic [PW-1:0]               rp_reg, rp_next;
    logic [PW-1:0]               wp_reg, wp_next;
    logic [CW-1:0]               wc_reg, wc_next;
    logic [fwsr_pkg::RES_W-1:0]  rc_reg, rc_next;
    logic [fwsr_pkg::STATUS_W-1:0] status_reg, status_next;

    logic [UW-1:0]               cap_ext;
    logic [UW-1:0]               cap_eff;
    logic [fwsr_pkg::RES_W-1:0]  rc_dec;
    logic [fwsr_pkg::RES_W:0]    rc_sum;
    logic [UW-1:0]               used_push;
    logic [UW-1:0]               used;

    assign cap_ext = UW'(capacity);
    assign cap_eff = (cap_ext > UW'(DEPTH)) ? UW'(DEPTH) : cap_ext;

    // a push gives back one reservation before the room check
    assign rc_dec    = (rc_reg != '0) ? rc_reg - fwsr_pkg::RES_W'(1) : rc_reg;
    assign used_push = UW'(wc_reg) + UW'(rc_dec);
    assign rc_sum    = {1'b0, rc_reg} + (fwsr_pkg::RES_W + 1)'(reserve_count);

    always_comb begin
        rp_next     = rp_reg;
        wp_next     = wp_reg;
        wc_next     = wc_reg;
        rc_next     = rc_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        if (step.go) begin
            status_next = fwsr_pkg::STAT_OK;
            case (step.action)
                fwsr_pkg::ACT_PUSH: begin
                    rc_next = rc_dec;
                    if (used_push >= cap_eff) begin
                        status_next = fwsr_pkg::STAT_OVERFLOW;
                    end else begin
                        wr_en   = 1'b1;
                        wp_next = (wp_reg == LAST_IDX) ? '0 : wp_reg + PW'(1);
                        wc_next = wc_reg + CW'(1);
                    end
                end
                fwsr_pkg::ACT_POP: begin
                    if (wc_reg == '0) begin
                        status_next = fwsr_pkg::STAT_UNDERFLOW;
                    end else begin
                        rp_next = (rp_reg == LAST_IDX) ? '0 : rp_reg + PW'(1);
                        wc_next = wc_reg - CW'(1);
                    end
                end
                fwsr_pkg::ACT_RESERVE: begin
                    rc_next = rc_sum[fwsr_pkg::RES_W] ? fwsr_pkg::RES_MAX
                                                      : rc_sum[fwsr_pkg::RES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg     <= '0;
            wp_reg     <= '0;
            wc_reg     <= '0;
            rc_reg     <= '0;
            status_reg <= fwsr_pkg::STAT_OK;
        end else begin
            rp_reg     <= rp_next;
            wp_reg     <= wp_next;
            wc_reg     <= wc_next;
            rc_reg     <= rc_next;
            status_reg <= status_next;
        end
    end

    assign wr_addr = wp_reg;
    assign rd_addr = rp_reg;

    assign used = UW'(wc_reg) + UW'(rc_reg);

    always_comb begin
        stat.status            = status_reg;
        stat.head_valid        = (wc_reg != '0);
        stat.stored_count      = fwsr_pkg::STORED_W'(wc_reg);
        stat.reserved_slots    = rc_reg;
        stat.is_full           = (used >= cap_eff);
        stat.is_empty          = (used == '0);
        stat.is_oversubscribed = (used > cap_eff);
    end

endmodule

`default_nettype wire

// ===== rtl/fifo_with_slot_reservation.sv =====
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    tuser: action; tdata: push_data, reserve_count
// m_        out  m_tvalid/m_tready    tuser: status; tdata: head word, counts, flags
// cfg_      in   cfg_valid/cfg_ready  cfg_data: capacity
//
// each item goes through idle, read and load: the update and the ram write in the
// transfer cycle, then a read of the new head, then the registered ram data goes into
// the output register once the slot is free; a new item is taken only after the load.
// reset is synchronous and active low; no clearing pass, the store's data is only
// used at entries already written. a stalled result holds in the output
// register while the next item is taken; that item then waits for the slot.
// a capacity write is taken only between items and goes ahead of the input
//
// top level of the queue; depends on fwsr_pkg, fwsr_ram, fwsr_ctrl and the
// assertion macro header
`default_nettype none

`include "fifo_with_slot_reservation_defines.svh"

module fifo_with_slot_reservation #(
    parameter int DEPTH      = fwsr_pkg::FWSR_DEPTH,
    parameter int DATA_WIDTH = fwsr_pkg::FWSR_DATA_WIDTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // push_data [31:0], reserve_count [36:32]
    input  wire logic [1:0]  s_tuser,   // action [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata,   // head_data [31:0], head_valid [32],
                                        // stored_count [37:33], reserved_slots [45:38],
                                        // is_full [46], is_empty [47],
                                        // is_oversubscribed [48]
    output logic      [1:0]  m_tuser,   // status [1:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data   // capacity
);

    localparam int PW = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [fwsr_pkg::CAP_W-1:0]    cap_reg;
    logic                          m_valid_reg, m_valid_next;
    fwsr_pkg::result_t             result_reg, result_next;
    logic [fwsr_pkg::STATUS_W-1:0] m_status_reg, m_status_next;

    fwsr_pkg::step_t  step;
    fwsr_pkg::stat_t  stat;
    logic             in_xfer;
    logic             out_free;
    logic             ram_we;
    logic             ram_re;
    logic [PW-1:0]    ram_waddr;
    logic [PW-1:0]    ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [63:0]      push_wide;
    logic [63:0]      head_wide;
    logic             head_on_empty;

    // capacity writes only between items, ahead of a waiting input transfer
    assign cfg_ready = aresetn && (state_reg == ST_IDLE);
    assign s_tready  = aresetn && (state_reg == ST_IDLE) && !cfg_valid;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= fwsr_pkg::CAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cfg_data;
        end
    end

    assign step.go     = in_xfer;
    assign step.action = s_tuser;

    fwsr_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .reserve_count (s_tdata[36:32]),
        .capacity      (cap_reg),
        .wr_en         (ram_we),
        .wr_addr       (ram_waddr),
        .rd_addr       (ram_raddr),
        .stat          (stat)
    );

    assign push_wide = {32'b0, s_tdata[31:0]};
    assign ram_wdata = push_wide[DATA_WIDTH-1:0];
    assign ram_re    = (state_reg == ST_READ);

    fwsr_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign head_wide = 64'(ram_rdata);

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg;
        result_next   = result_reg;
        m_status_next = m_status_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                // ram data holds here until the output slot frees up
                if (out_free) begin
                    m_valid_next                  = 1'b1;
                    m_status_next                 = stat.status;
                    result_next.pad               = '0;
                    result_next.head_data         = stat.head_valid ? head_wide[31:0] : '0;
                    result_next.head_valid        = stat.head_valid;
                    result_next.stored_count      = stat.stored_count;
                    result_next.reserved_slots    = stat.reserved_slots;
                    result_next.is_full           = stat.is_full;
                    result_next.is_empty          = stat.is_empty;
                    result_next.is_oversubscribed = stat.is_oversubscribed;
                    state_next                    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg   <= result_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result_reg;
    assign m_tuser  = m_status_reg;

    assign head_on_empty = result_reg.is_empty && result_reg.head_valid;

    `FWSR_ASSERT(a_write_on_transfer, ram_we |-> in_xfer, "ram write without a transfer")
    `FWSR_ASSERT(a_transfer_starts_read, in_xfer |=> (state_reg == ST_READ), "no head read")
    `FWSR_ASSERT(a_empty_no_head, m_valid_reg |-> !head_on_empty, "empty queue shows a head")
    `FWSR_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (state_reg == ST_IDLE && !m_valid_reg), "not idle")

endmodule

`default_nettype wire
